// File: rtl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and constants of the polyline length splitter.
// ----------------------------------------------------------------------------
package pls_pkg;

   // width of the split length register
   localparam int LIM_BITS = 32;
   // bits of j * split_length for up to 31 cuts
   localparam int JLIM_BITS = 37;

   typedef enum logic [2:0] {
      K_FIRST = 3'b001,
      K_PASS  = 3'b010,
      K_EDGE  = 3'b100
   } pls_kind_type;

   typedef struct packed {
      pls_kind_type kind;
      logic         fin;
   } pls_cmd_type;

endpackage

// File: rtl/pls_if.sv
// ----------------------------------------------------------------------------
// pls_if
// Valid/ready channels for the points in and the points out.
// ----------------------------------------------------------------------------
interface pls_req_if #(parameter int COORD_BITS = 32);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic                         final_point;

   modport source (output valid, output point_x, output point_y, output final_point,
                   input ready);
   modport sink (input valid, input point_x, input point_y, input final_point,
                 output ready);
endinterface

interface pls_rsp_if #(parameter int COORD_BITS = 32);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] out_x;
   logic signed [COORD_BITS-1:0] out_y;
   logic                         opens_segment;
   logic                         end_marker;
   logic                         drop_trailing;
   logic                         truncated;
   logic                         last_of_run;

   modport source (output valid, output out_x, output out_y, output opens_segment,
                   output end_marker, output drop_trailing, output truncated,
                   output last_of_run, input ready);
   modport sink (input valid, input out_x, input out_y, input opens_segment,
                 input end_marker, input drop_trailing, input truncated,
                 input last_of_run, output ready);
endinterface

// File: rtl/pls_front.sv
// ----------------------------------------------------------------------------
// pls_front
// Accepts points, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module pls_front #(
   parameter int COORD_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   pls_req_if.sink                           req_ch,
   input  logic [pls_pkg::LIM_BITS-1:0]      lim,
   output logic                              q_valid,
   input  logic                              q_pop,
   output logic signed [COORD_BITS-1:0]      q_x,
   output logic signed [COORD_BITS-1:0]      q_y,
   output pls_pkg::pls_cmd_type              q_cmd
);
   import pls_pkg::*;

   localparam int QD  = 2;
   localparam int QAW = $clog2(QD);
   localparam int QCW = $clog2(QD + 1);

   logic signed [COORD_BITS-1:0] ent_x_ff [QD];
   logic signed [COORD_BITS-1:0] ent_y_ff [QD];
   pls_cmd_type                  ent_cmd_ff [QD];
   logic [QAW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCW-1:0] cnt_ff, cnt_in;
   logic           have_prev_ff, have_prev_in;
   logic           push;
   pls_cmd_type    cmd;

   assign req_ch.ready = (cnt_ff != QCW'(QD));
   assign push         = req_ch.valid && req_ch.ready;
   assign q_valid      = (cnt_ff != '0);
   assign q_x          = ent_x_ff[rd_ff];
   assign q_y          = ent_y_ff[rd_ff];
   assign q_cmd        = ent_cmd_ff[rd_ff];

   always_comb begin
      cmd.fin = req_ch.final_point;
      if (!have_prev_ff) begin
         cmd.kind = K_FIRST;
      end else if (lim == '0) begin
         cmd.kind = K_PASS;
      end else begin
         cmd.kind = K_EDGE;
      end
      wr_in        = push ? QAW'(wr_ff + 1'b1) : wr_ff;
      rd_in        = q_pop ? QAW'(rd_ff + 1'b1) : rd_ff;
      cnt_in       = QCW'(cnt_ff + QCW'(push) - QCW'(q_pop));
      // a final point leaves the next item without a previous point
      have_prev_in = push ? !req_ch.final_point : have_prev_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff        <= '0;
         rd_ff        <= '0;
         cnt_ff       <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         wr_ff        <= wr_in;
         rd_ff        <= rd_in;
         cnt_ff       <= cnt_in;
         have_prev_ff <= have_prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_x_ff[wr_ff]   <= req_ch.point_x;
         ent_y_ff[wr_ff]   <= req_ch.point_y;
         ent_cmd_ff[wr_ff] <= cmd;
      end
   end

endmodule

// File: rtl/pls_back.sv
// ----------------------------------------------------------------------------
// pls_back
// Sequencer: edge length by serial squares and square root, cut points by
// serial multiply and divide, result register toward the output channel.
// ----------------------------------------------------------------------------
module pls_back #(
   parameter int COORD_BITS = 32,
   parameter int MAX_SPLITS = 30
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   output logic                              q_pop,
   input  logic signed [COORD_BITS-1:0]      q_x,
   input  logic signed [COORD_BITS-1:0]      q_y,
   input  pls_pkg::pls_cmd_type              q_cmd,
   input  logic [pls_pkg::LIM_BITS-1:0]      lim,
   pls_rsp_if.source                         rsp_ch
);
   import pls_pkg::*;

   localparam int C    = COORD_BITS;
   localparam int CW   = (C + 2 > JLIM_BITS + 1) ? C + 2 : JLIM_BITS + 1;
   localparam int MBW  = (C > JLIM_BITS) ? C : JLIM_BITS;
   localparam int PW   = (2 * C + 1 > C + JLIM_BITS + 1) ? 2 * C + 1 : C + JLIM_BITS + 1;
   localparam int SW   = 2 * C + 2;
   localparam int RW   = C + 4;
   localparam int CNW  = $clog2(C + 1);
   localparam int JW   = $clog2(MAX_SPLITS + 1);
   localparam int TOPW = LIM_BITS + $clog2(MAX_SPLITS + 2);

   typedef enum logic [10:0] {
      S_IDLE = 11'b00000000001,
      S_SQR  = 11'b00000000010,
      S_ROOT = 11'b00000000100,
      S_PLAN = 11'b00000001000,
      S_MUL  = 11'b00000010000,
      S_DIV  = 11'b00000100000,
      S_CHK  = 11'b00001000000,
      S_CUTA = 11'b00010000000,
      S_CUTB = 11'b00100000000,
      S_PNT  = 11'b01000000000,
      S_FIN  = 11'b10000000000
   } st_type;

   st_type st_ff, st_in;

   // point state
   logic signed [C-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [LIM_BITS-1:0] run_ff, run_in;
   logic [1:0]          seg_ff, seg_in;

   // working registers
   logic signed [C-1:0] x_ff, x_in, y_ff, y_in, cx_ff, cx_in, cy_ff, cy_in;
   logic                fin_ff, fin_in, first_ff, first_in, trunc_ff, trunc_in;
   logic                nx_ff, nx_in, ny_ff, ny_in, axis_ff, axis_in, phase_ff, phase_in;
   logic                hit_ff, hit_in, last_ff, last_in;
   logic [C-1:0]        ax_ff, ax_in, ay_ff, ay_in;
   logic [CW-1:0]       total_ff, total_in, jlim_ff, jlim_in;
   logic [JLIM_BITS-1:0] num_ff, num_in;
   logic [JW-1:0]       j_ff, j_in;
   logic [TOPW-1:0]     limtop_ff;
   logic [PW-1:0]       acc_ff, acc_in, mc_ff, mc_in;
   logic [MBW-1:0]      mb_ff, mb_in;
   logic [SW-1:0]       src_ff, src_in;
   logic [RW-1:0]       rem_ff, rem_in;
   logic [C:0]          root_ff, root_in;
   logic [C+1:0]        drem_ff, drem_in;
   logic [C-1:0]        dlo_ff, dlo_in, q_ff, q_in;
   logic [CNW-1:0]      cnt_ff, cnt_in;

   // result register
   logic                rsp_vld_ff, rsp_vld_in;
   logic signed [C-1:0] ox_ff, ox_in, oy_ff, oy_in;
   logic                oopen_ff, oopen_in, oend_ff, oend_in, odrop_ff, odrop_in;
   logic                otrunc_ff, otrunc_in, olast_ff, olast_in;

   // combinational helpers
   logic [C:0]          dx, dy, adx, ady;
   logic [RW-1:0]       rem_t, trial;
   logic                root_ge, div_ge;
   logic [C+1:0]        drem_t, dvs;
   logic [C-1:0]        q_nx, mag;
   logic signed [C-1:0] base;
   logic [C:0]          coord;
   logic [LIM_BITS-1:0] run_c;
   logic [CW-1:0]       total_c, left;
   logic                out_free, emit;

   assign out_free = !rsp_vld_ff || rsp_ch.ready;

   assign rsp_ch.valid         = rsp_vld_ff;
   assign rsp_ch.out_x         = ox_ff;
   assign rsp_ch.out_y         = oy_ff;
   assign rsp_ch.opens_segment = oopen_ff;
   assign rsp_ch.end_marker    = oend_ff;
   assign rsp_ch.drop_trailing = odrop_ff;
   assign rsp_ch.truncated     = otrunc_ff;
   assign rsp_ch.last_of_run   = olast_ff;

   always_comb begin
      dx      = {q_x[C-1], q_x} - {prev_x_ff[C-1], prev_x_ff};
      dy      = {q_y[C-1], q_y} - {prev_y_ff[C-1], prev_y_ff};
      adx     = dx[C] ? (C+1)'(-dx) : dx;
      ady     = dy[C] ? (C+1)'(-dy) : dy;
      // one root digit: bring down two bits, try 4r+1
      rem_t   = {rem_ff[RW-3:0], src_ff[SW-1:SW-2]};
      trial   = RW'({root_ff, 2'b01});
      root_ge = (rem_t >= trial);
      // one quotient bit of the rounded interpolation
      drem_t  = {drem_ff[C:0], dlo_ff[C-1]};
      dvs     = {1'b0, root_ff};
      div_ge  = (drem_t >= dvs);
      q_nx    = {q_ff[C-2:0], div_ge};
      mag     = axis_ff ? ay_ff : ax_ff;
      base    = axis_ff ? prev_y_ff : prev_x_ff;
      if (axis_ff ? ny_ff : nx_ff) begin
         coord = {base[C-1], base} - {1'b0, q_nx};
      end else begin
         coord = {base[C-1], base} + {1'b0, q_nx};
      end
      run_c   = (run_ff > lim) ? lim : run_ff;
      total_c = CW'(run_c) + CW'(root_ff);
      left    = total_ff - jlim_ff;
   end

   always_comb begin
      st_in     = st_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      run_in    = run_ff;
      seg_in    = seg_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      fin_in    = fin_ff;
      first_in  = first_ff;
      trunc_in  = trunc_ff;
      nx_in     = nx_ff;
      ny_in     = ny_ff;
      axis_in   = axis_ff;
      phase_in  = phase_ff;
      hit_in    = hit_ff;
      last_in   = last_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      total_in  = total_ff;
      jlim_in   = jlim_ff;
      num_in    = num_ff;
      j_in      = j_ff;
      acc_in    = acc_ff;
      mc_in     = mc_ff;
      mb_in     = mb_ff;
      src_in    = src_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      drem_in   = drem_ff;
      dlo_in    = dlo_ff;
      q_in      = q_ff;
      cnt_in    = cnt_ff;
      q_pop     = 1'b0;
      emit      = 1'b0;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      oopen_in  = oopen_ff;
      oend_in   = 1'b0;
      odrop_in  = 1'b0;
      otrunc_in = otrunc_ff;
      olast_in  = olast_ff;

      case (st_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               x_in     = q_x;
               y_in     = q_y;
               fin_in   = q_cmd.fin;
               trunc_in = 1'b0;
               nx_in    = dx[C];
               ny_in    = dy[C];
               ax_in    = adx[C-1:0];
               ay_in    = ady[C-1:0];
               case (q_cmd.kind)
                  K_FIRST: begin
                     first_in = 1'b1;
                     run_in   = '0;
                     st_in    = S_PNT;
                  end
                  K_PASS: begin
                     first_in = 1'b0;
                     run_in   = '0;
                     st_in    = S_PNT;
                  end
                  default: begin
                     first_in = 1'b0;
                     acc_in   = '0;
                     mc_in    = PW'(adx[C-1:0]);
                     mb_in    = MBW'(adx[C-1:0]);
                     phase_in = 1'b0;
                     st_in    = S_SQR;
                  end
               endcase
            end
         end
         S_SQR: begin
            // shift-add squares, dx first then dy into the same sum
            if (mb_ff != '0) begin
               if (mb_ff[0]) begin
                  acc_in = acc_ff + mc_ff;
               end
               mc_in = {mc_ff[PW-2:0], 1'b0};
               mb_in = mb_ff >> 1;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
               mc_in    = PW'(ay_ff);
               mb_in    = MBW'(ay_ff);
            end else begin
               src_in  = SW'(acc_ff);
               rem_in  = '0;
               root_in = '0;
               cnt_in  = '0;
               st_in   = S_ROOT;
            end
         end
         S_ROOT: begin
            rem_in  = root_ge ? RW'(rem_t - trial) : rem_t;
            root_in = {root_ff[C-1:0], root_ge};
            src_in  = {src_ff[SW-3:0], 2'b00};
            cnt_in  = CNW'(cnt_ff + 1'b1);
            if (cnt_ff == CNW'(C)) begin
               st_in = S_PLAN;
            end
         end
         S_PLAN: begin
            total_in = total_c;
            if (total_c > CW'(lim)) begin
               trunc_in = (CW'(limtop_ff) <= total_c);
               run_in   = run_c;
               j_in     = JW'(1);
               jlim_in  = CW'(lim);
               num_in   = JLIM_BITS'(lim - run_c);
               axis_in  = 1'b0;
               acc_in   = PW'(root_ff >> 1);
               mc_in    = PW'(ax_ff);
               mb_in    = MBW'(JLIM_BITS'(lim - run_c));
               st_in    = S_MUL;
            end else begin
               run_in = total_c[LIM_BITS-1:0];
               st_in  = S_PNT;
            end
         end
         S_MUL: begin
            if (mb_ff != '0) begin
               if (mb_ff[0]) begin
                  acc_in = acc_ff + mc_ff;
               end
               mc_in = {mc_ff[PW-2:0], 1'b0};
               mb_in = mb_ff >> 1;
            end else begin
               drem_in = (C+2)'(acc_ff >> C);
               dlo_in  = acc_ff[C-1:0];
               q_in    = '0;
               cnt_in  = '0;
               st_in   = S_DIV;
            end
         end
         S_DIV: begin
            drem_in = div_ge ? (C+2)'(drem_t - dvs) : drem_t;
            dlo_in  = {dlo_ff[C-2:0], 1'b0};
            q_in    = q_nx;
            cnt_in  = CNW'(cnt_ff + 1'b1);
            if (cnt_ff == CNW'(C - 1)) begin
               if (!axis_ff) begin
                  cx_in   = coord[C-1:0];
                  axis_in = 1'b1;
                  acc_in  = PW'(root_ff >> 1);
                  mc_in   = PW'(ay_ff);
                  mb_in   = MBW'(num_ff);
                  st_in   = S_MUL;
               end else begin
                  cy_in = coord[C-1:0];
                  st_in = S_CHK;
               end
            end
         end
         S_CHK: begin
            hit_in  = (cx_ff == x_ff) && (cy_ff == y_ff);
            last_in = (j_ff == JW'(MAX_SPLITS)) || (jlim_ff + CW'(lim) > total_ff);
            st_in   = (num_ff != '0) ? S_CUTA : S_CUTB;
         end
         S_CUTA: begin
            if (out_free) begin
               emit      = 1'b1;
               ox_in     = cx_ff;
               oy_in     = cy_ff;
               oopen_in  = 1'b0;
               otrunc_in = trunc_ff;
               olast_in  = 1'b0;
               seg_in    = (seg_ff == 2'd2) ? seg_ff : 2'(seg_ff + 1'b1);
               st_in     = S_CUTB;
            end
         end
         S_CUTB: begin
            if (out_free) begin
               emit      = 1'b1;
               ox_in     = cx_ff;
               oy_in     = cy_ff;
               oopen_in  = 1'b1;
               otrunc_in = trunc_ff;
               olast_in  = last_ff && hit_ff && !fin_ff;
               seg_in    = 2'd1;
               if (!last_ff) begin
                  j_in    = JW'(j_ff + 1'b1);
                  jlim_in = jlim_ff + CW'(lim);
                  num_in  = JLIM_BITS'(num_ff + JLIM_BITS'(lim));
                  axis_in = 1'b0;
                  acc_in  = PW'(root_ff >> 1);
                  mc_in   = PW'(ax_ff);
                  mb_in   = MBW'(JLIM_BITS'(num_ff + JLIM_BITS'(lim)));
                  st_in   = S_MUL;
               end else if (hit_ff) begin
                  // last cut landed on the point itself
                  run_in    = '0;
                  prev_x_in = x_ff;
                  prev_y_in = y_ff;
                  st_in     = fin_ff ? S_FIN : S_IDLE;
               end else begin
                  run_in = (left > CW'(lim)) ? lim : left[LIM_BITS-1:0];
                  st_in  = S_PNT;
               end
            end
         end
         S_PNT: begin
            if (out_free) begin
               emit      = 1'b1;
               ox_in     = x_ff;
               oy_in     = y_ff;
               oopen_in  = first_ff;
               otrunc_in = trunc_ff;
               olast_in  = !fin_ff;
               if (first_ff) begin
                  seg_in = 2'd1;
               end else begin
                  seg_in = (seg_ff == 2'd2) ? seg_ff : 2'(seg_ff + 1'b1);
               end
               prev_x_in = x_ff;
               prev_y_in = y_ff;
               st_in     = fin_ff ? S_FIN : S_IDLE;
            end
         end
         S_FIN: begin
            if (out_free) begin
               emit      = 1'b1;
               ox_in     = '0;
               oy_in     = '0;
               oopen_in  = 1'b0;
               oend_in   = 1'b1;
               odrop_in  = (seg_ff <= 2'd1);
               otrunc_in = trunc_ff;
               olast_in  = 1'b1;
               seg_in    = '0;
               run_in    = '0;
               prev_x_in = '0;
               prev_y_in = '0;
               st_in     = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase

      if (emit) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= S_IDLE;
         rsp_vld_ff <= 1'b0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         run_ff     <= '0;
         seg_ff     <= '0;
      end else begin
         st_ff      <= st_in;
         rsp_vld_ff <= rsp_vld_in;
         prev_x_ff  <= prev_x_in;
         prev_y_ff  <= prev_y_in;
         run_ff     <= run_in;
         seg_ff     <= seg_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      fin_ff    <= fin_in;
      first_ff  <= first_in;
      trunc_ff  <= trunc_in;
      nx_ff     <= nx_in;
      ny_ff     <= ny_in;
      axis_ff   <= axis_in;
      phase_ff  <= phase_in;
      hit_ff    <= hit_in;
      last_ff   <= last_in;
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      total_ff  <= total_in;
      jlim_ff   <= jlim_in;
      num_ff    <= num_in;
      j_ff      <= j_in;
      limtop_ff <= TOPW'(lim) * TOPW'(MAX_SPLITS + 1);
      acc_ff    <= acc_in;
      mc_ff     <= mc_in;
      mb_ff     <= mb_in;
      src_ff    <= src_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      drem_ff   <= drem_in;
      dlo_ff    <= dlo_in;
      q_ff      <= q_in;
      cnt_ff    <= cnt_in;
      ox_ff     <= ox_in;
      oy_ff     <= oy_in;
      oopen_ff  <= oopen_in;
      oend_ff   <= rsp_vld_in ? (emit ? oend_in : oend_ff) : oend_ff;
      odrop_ff  <= emit ? odrop_in : odrop_ff;
      otrunc_ff <= otrunc_in;
      olast_ff  <= olast_in;
   end

`ifndef SYNTH
   // a cut coordinate never moves past the far end of the edge
   a_quot_le_mag: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_DIV && cnt_ff == CNW'(C - 1)) |-> (q_nx <= mag))
      else $error("cut quotient exceeds edge delta");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && oend_ff) |-> olast_ff)
      else $error("end item not flagged last of run");

   a_seg_sat: assert property (@(posedge clock) disable iff (reset)
      seg_ff != 2'd3)
      else $error("segment point count past saturation");

   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_ch.ready) |=> (rsp_vld_ff && $stable(ox_ff) && $stable(olast_ff)))
      else $error("pending result overwritten");
`endif

endmodule

// File: rtl/polyline_length_splitter.sv
// ----------------------------------------------------------------------------
// polyline_length_splitter
// Splits a polyline into segments no longer than split_length.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  req_ch    in   valid / ready          point_x, point_y, final_point
//  rsp_ch    out  valid / ready          out_x, out_y, opens_segment, end_marker,
//                                        drop_trailing, truncated, last_of_run
//  csr       in   csr_wr_en              csr_wr_data = split_length
//
//  first point or split_length zero: the point goes straight out, an end item follows a final one
//  edge: serial squaring and a restoring square root give the edge length, then each cut
//    is reckoned for x and y in the shared shift-add multiplier and restoring divider,
//    followed by a check step and the result items
//  a two-entry queue takes new points while the sequencer works; a held result stalls it
//  reset is synchronous and clears the line state and split_length
// ----------------------------------------------------------------------------
module polyline_length_splitter #(
   parameter int MAX_SPLITS = 30,
   parameter int COORD_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   pls_req_if.sink                       req_ch,
   pls_rsp_if.source                     rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [pls_pkg::LIM_BITS-1:0]  csr_wr_data
);
   import pls_pkg::*;

   logic [LIM_BITS-1:0]          lim_ff, lim_in;
   logic                         q_valid, q_pop;
   logic signed [COORD_BITS-1:0] q_x, q_y;
   pls_cmd_type                  q_cmd;

   assign lim_in = csr_wr_en ? csr_wr_data : lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= '0;
      end else begin
         lim_ff <= lim_in;
      end
   end

   pls_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .lim     (lim_ff),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .q_x     (q_x),
      .q_y     (q_y),
      .q_cmd   (q_cmd)
   );

   pls_back #(
      .COORD_BITS (COORD_BITS),
      .MAX_SPLITS (MAX_SPLITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .q_x     (q_x),
      .q_y     (q_y),
      .q_cmd   (q_cmd),
      .lim     (lim_ff),
      .rsp_ch  (rsp_ch)
   );

endmodule
